[rtl/bounded_event_log_with_cursor_core_defines.svh]
// assertion macros shared by the event log rtl
`ifndef BOUNDED_EVENT_LOG_WITH_CURSOR_CORE_DEFINES_SVH
`define BOUNDED_EVENT_LOG_WITH_CURSOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define BEL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BEL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BEL_ASSERT(lbl, prop, msg)
`define BEL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/bel_pkg.sv]
// types, codes and constants of the event log
package bel_pkg;

    localparam int BEL_LOG_DEPTH = 20;

    localparam int BEL_CFG_IDX_W  = 1;
    localparam int BEL_CFG_DATA_W = 12;

    localparam logic [11:0] BEL_HIGH_LIMIT_RST = 12'd2280;
    localparam logic [11:0] BEL_LOW_LIMIT_RST  = 12'd2120;

    typedef enum logic [BEL_CFG_IDX_W-1:0] {
        CFG_HIGH_LIMIT = 1'd0,
        CFG_LOW_LIMIT  = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_NEXT     = 3'd1,
        CMD_PREV     = 3'd2,
        CMD_LIVE_ON  = 3'd3,
        CMD_LIVE_OFF = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ECHO     = 3'd0,
        ST_MOVED    = 3'd1,
        ST_NEWEST   = 3'd2,
        ST_OLDEST   = 3'd3,
        ST_LIVE_ON  = 3'd4,
        ST_PAUSED   = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ALERT_NORMAL = 2'd0,
        ALERT_HIGH   = 2'd1,
        ALERT_LOW    = 2'd2
    } t_alert;

    // where the result fields come from
    typedef enum logic [1:0] {
        SRC_DESC     = 2'd0,
        SRC_MEM_FULL = 2'd1,
        SRC_MEM_ID   = 2'd2
    } t_src;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] stamp;
        logic [8:0]  power;
        logic [11:0] voltage;
        logic [9:0]  frequency;
        t_alert      alert;
    } t_entry;

    typedef struct packed {
        logic    valid;
        t_status status;
        t_src    src;
        t_entry  entry;
    } t_desc;

    typedef struct packed {
        logic empty;
        logic cursor_valid;
    } t_log_flags;

endpackage

[rtl/bel_in_if.sv]
// command channel into the event log
interface bel_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [8:0]  power_reading;
    logic [11:0] voltage_reading;
    logic [9:0]  frequency_reading;
    logic [31:0] event_time;

    modport source (
        output valid, command, power_reading, voltage_reading, frequency_reading, event_time,
        input  ready
    );
    modport sink (
        input  valid, command, power_reading, voltage_reading, frequency_reading, event_time,
        output ready
    );
endinterface

[rtl/bel_out_if.sv]
// result channel out of the event log
interface bel_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [31:0] entry_time;
    logic [8:0]  entry_power;
    logic [11:0] entry_voltage;
    logic [9:0]  entry_frequency;
    logic [1:0]  entry_alert;

    modport source (
        output valid, status, entry_id, entry_time, entry_power, entry_voltage,
               entry_frequency, entry_alert,
        input  ready
    );
    modport sink (
        input  valid, status, entry_id, entry_time, entry_power, entry_voltage,
               entry_frequency, entry_alert,
        output ready
    );
endinterface

[rtl/bel_mem.sv]
// entry storage with registered read port
module bel_mem #(
    parameter int LOG_DEPTH = bel_pkg::BEL_LOG_DEPTH,
    parameter int SLOT_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [SLOT_W-1:0]    i_wr_slot,
    input  bel_pkg::t_entry      i_wr_entry,
    input  logic                 i_rd_en,
    input  logic [SLOT_W-1:0]    i_rd_slot,
    output bel_pkg::t_entry      o_rd_entry
);
    import bel_pkg::*;

    t_entry r_mem [LOG_DEPTH];
    t_entry r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_entry;
        end
    end

    // read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_slot];
        end
    end

    assign o_rd_entry = r_rd;
endmodule

[rtl/bel_ctrl.sv]
// command decode, log pointers, cursor and limit registers
module bel_ctrl #(
    parameter int LOG_DEPTH = bel_pkg::BEL_LOG_DEPTH,
    parameter int SLOT_W    = 5,
    parameter int CNT_W     = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bel_pkg::BEL_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bel_pkg::BEL_CFG_DATA_W-1:0] i_cfg_data,
    bel_in_if.sink                            i_in,
    input  logic                              i_can_take,
    output logic                              o_wr_en,
    output logic [SLOT_W-1:0]                 o_wr_slot,
    output bel_pkg::t_entry                   o_wr_entry,
    output logic                              o_rd_en,
    output logic [SLOT_W-1:0]                 o_rd_slot,
    output bel_pkg::t_desc                    o_desc,
    output bel_pkg::t_log_flags               o_flags
);
    import bel_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LOG_DEPTH - 1);
    localparam logic [SLOT_W+1:0] DEPTH_W2  = (SLOT_W+2)'(LOG_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(LOG_DEPTH);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    logic [11:0]       r_high_limit;
    logic [11:0]       r_low_limit;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_cursor, n_cursor;
    logic              r_cur_valid, n_cur_valid;
    logic              r_live, n_live;
    logic [31:0]       r_next_id, n_next_id;
    t_desc             r_desc, n_desc;

    logic              w_accept;
    logic              w_full;
    logic [SLOT_W-1:0] w_old_e;
    logic [CNT_W-1:0]  w_cnt_e;
    logic [SLOT_W+1:0] w_sum;
    logic [SLOT_W-1:0] w_add_slot;
    t_alert            w_alert;
    t_entry            w_new_entry;
    logic [SLOT_W+1:0] w_pos_wide;
    logic [SLOT_W-1:0] w_pos;
    logic              w_can_next;
    logic              w_can_prev;
    t_entry            w_id_only;

    // pipeline moves when the result stage is free or being drained
    assign i_in.ready = !r_desc.valid || i_can_take;
    assign w_accept   = i_in.valid && i_in.ready;

    // slot arithmetic for an add, with eviction when full
    assign w_full     = (r_count == DEPTH_CNT);
    assign w_old_e    = w_full ? slot_inc(r_oldest) : r_oldest;
    assign w_cnt_e    = w_full ? r_count - 1'b1 : r_count;
    assign w_sum      = (SLOT_W+2)'(w_old_e) + (SLOT_W+2)'(w_cnt_e);
    assign w_add_slot = (w_sum >= DEPTH_W2) ? SLOT_W'(w_sum - DEPTH_W2) : SLOT_W'(w_sum);

    // alert class from the two limits
    always_comb begin
        if (i_in.voltage_reading > r_high_limit) begin
            w_alert = ALERT_HIGH;
        end else if (i_in.voltage_reading < r_low_limit) begin
            w_alert = ALERT_LOW;
        end else begin
            w_alert = ALERT_NORMAL;
        end
    end

    assign w_new_entry = '{id: r_next_id, stamp: i_in.event_time,
                           power: i_in.power_reading, voltage: i_in.voltage_reading,
                           frequency: i_in.frequency_reading, alert: w_alert};

    // cursor position counted from the oldest entry
    assign w_pos_wide = (r_cursor >= r_oldest)
                      ? (SLOT_W+2)'(r_cursor) - (SLOT_W+2)'(r_oldest)
                      : (SLOT_W+2)'(r_cursor) + DEPTH_W2 - (SLOT_W+2)'(r_oldest);
    assign w_pos      = SLOT_W'(w_pos_wide);
    assign w_can_next = r_cur_valid && ((CNT_W+1)'(w_pos) + 1'b1 < (CNT_W+1)'(r_count));
    assign w_can_prev = r_cur_valid && (w_pos != '0) && ((CNT_W+1)'(w_pos) < (CNT_W+1)'(r_count));

    assign w_id_only = '0;

    // command decode and next state
    always_comb begin
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_cur_valid = r_cur_valid;
        n_live      = r_live;
        n_next_id   = r_next_id;
        n_desc      = '0;
        o_wr_en     = 1'b0;
        o_rd_slot   = r_cursor;
        case (t_cmd'(i_in.command))
            CMD_ADD: begin
                o_wr_en   = w_accept;
                n_oldest  = w_old_e;
                n_count   = w_cnt_e + 1'b1;
                n_next_id = r_next_id + 32'd1;
                if (w_full && r_cur_valid && (r_cursor == r_oldest)) begin
                    if (r_count > CNT_W'(1)) begin
                        n_cursor = slot_inc(r_oldest);
                    end else begin
                        n_cur_valid = 1'b0;
                    end
                end
                if (w_cnt_e == '0) begin
                    n_cursor    = w_add_slot;
                    n_cur_valid = 1'b1;
                end
                n_desc.valid  = r_live;
                n_desc.status = ST_ECHO;
                n_desc.src    = SRC_DESC;
                n_desc.entry  = w_new_entry;
            end
            CMD_NEXT: begin
                n_desc.valid = 1'b1;
                if (w_can_next) begin
                    n_cursor      = slot_inc(r_cursor);
                    o_rd_slot     = slot_inc(r_cursor);
                    n_desc.status = ST_MOVED;
                    n_desc.src    = SRC_MEM_FULL;
                end else begin
                    n_desc.status = ST_NEWEST;
                    n_desc.src    = r_cur_valid ? SRC_MEM_ID : SRC_DESC;
                    n_desc.entry  = w_id_only;
                end
            end
            CMD_PREV: begin
                n_desc.valid = 1'b1;
                if (w_can_prev) begin
                    n_cursor      = slot_dec(r_cursor);
                    o_rd_slot     = slot_dec(r_cursor);
                    n_desc.status = ST_MOVED;
                    n_desc.src    = SRC_MEM_FULL;
                end else begin
                    n_desc.status = ST_OLDEST;
                    n_desc.src    = r_cur_valid ? SRC_MEM_ID : SRC_DESC;
                    n_desc.entry  = w_id_only;
                end
            end
            CMD_LIVE_ON: begin
                n_live        = 1'b1;
                n_desc.valid  = !r_live;
                n_desc.status = ST_LIVE_ON;
                n_desc.src    = SRC_DESC;
            end
            CMD_LIVE_OFF: begin
                n_live        = 1'b0;
                n_desc.valid  = r_live;
                n_desc.status = ST_PAUSED;
                n_desc.src    = SRC_DESC;
            end
            CMD_CLEAR: begin
                n_oldest      = '0;
                n_count       = '0;
                n_cursor      = '0;
                n_cur_valid   = 1'b0;
                n_next_id     = 32'd1;
                n_desc.valid  = 1'b1;
                n_desc.status = ST_CLEARED;
                n_desc.src    = SRC_DESC;
            end
            default: begin
                n_desc = '0;
            end
        endcase
    end

    assign o_wr_slot  = w_add_slot;
    assign o_wr_entry = w_new_entry;
    assign o_rd_en    = w_accept;

    // log state, updated on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_live      <= 1'b0;
            r_next_id   <= 32'd1;
        end else if (w_accept) begin
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_cur_valid <= n_cur_valid;
            r_live      <= n_live;
            r_next_id   <= n_next_id;
        end
    end

    // result descriptor stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= '0;
        end else if (i_in.ready) begin
            r_desc <= w_accept ? n_desc : '0;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_limit <= BEL_HIGH_LIMIT_RST;
            r_low_limit  <= BEL_LOW_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                default: begin
                    r_high_limit <= r_high_limit;
                end
            endcase
        end
    end

    assign o_desc  = r_desc;
    assign o_flags = '{empty: (r_count == '0), cursor_valid: r_cur_valid};
endmodule

[rtl/bel_outreg.sv]
// result assembly and output register
module bel_outreg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bel_pkg::t_desc  i_desc,
    input  bel_pkg::t_entry i_rd_entry,
    output logic            o_can_take,
    bel_out_if.source       o_out
);
    import bel_pkg::*;

    logic    r_valid;
    t_status r_status;
    t_entry  r_entry;
    t_entry  w_entry;
    logic    w_load;

    // pick the field source
    always_comb begin
        case (i_desc.src)
            SRC_MEM_FULL: w_entry = i_rd_entry;
            SRC_MEM_ID: begin
                w_entry    = '0;
                w_entry.id = i_rd_entry.id;
            end
            default: w_entry = i_desc.entry;
        endcase
    end

    assign o_can_take = !r_valid || o_out.ready;
    assign w_load     = i_desc.valid && o_can_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= i_desc.status;
            r_entry  <= w_entry;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.status          = r_status;
    assign o_out.entry_id        = r_entry.id;
    assign o_out.entry_time      = r_entry.stamp;
    assign o_out.entry_power     = r_entry.power;
    assign o_out.entry_voltage   = r_entry.voltage;
    assign o_out.entry_frequency = r_entry.frequency;
    assign o_out.entry_alert     = r_entry.alert;
endmodule

[rtl/bounded_event_log_with_cursor_core.sv]
// top level of the bounded event log with navigation cursor
//
// Commands arrive on i_in (valid/ready, one beat per command) and results
// leave on o_out (valid/ready). Add stores an event, next and prev move the
// cursor, live on and live off switch the echo of added events, clear empties
// the log. Limits are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// A command's descriptor and its entry read are registered at the edge that
// takes its command beat; the output register then loads them once it is free.
// Throughput: one command per cycle while o_out is not stalled, set by the
// single read port of the entry store, which serves one cursor move per beat.
// Commands without a result (quiet add, repeated live on or off, unused codes)
// leave nothing on o_out.
// Reset: log empty, cursor invalid, live echo paused, ids restart at 1,
// limits back to 228.0 V and 212.0 V. Entry storage is not cleared.
// Stall: when o_out.ready stays low, the output register and the descriptor
// stage fill up, then i_in.ready drops until the receiver takes a beat.
`include "bounded_event_log_with_cursor_core_defines.svh"

module bounded_event_log_with_cursor_core #(
    parameter int LOG_DEPTH = bel_pkg::BEL_LOG_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bel_pkg::BEL_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bel_pkg::BEL_CFG_DATA_W-1:0] i_cfg_data,
    bel_in_if.sink                             i_in,
    bel_out_if.source                          o_out
);
    import bel_pkg::*;

    localparam int SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LOG_DEPTH + 1);

    logic              w_wr_en;
    logic [SLOT_W-1:0] w_wr_slot;
    t_entry            w_wr_entry;
    logic              w_rd_en;
    logic [SLOT_W-1:0] w_rd_slot;
    t_entry            w_rd_entry;
    t_desc             w_desc;
    t_log_flags        w_flags;
    logic              w_can_take;

    bel_ctrl #(
        .LOG_DEPTH (LOG_DEPTH),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_can_take (w_can_take),
        .o_wr_en    (w_wr_en),
        .o_wr_slot  (w_wr_slot),
        .o_wr_entry (w_wr_entry),
        .o_rd_en    (w_rd_en),
        .o_rd_slot  (w_rd_slot),
        .o_desc     (w_desc),
        .o_flags    (w_flags)
    );

    bel_mem #(
        .LOG_DEPTH (LOG_DEPTH),
        .SLOT_W    (SLOT_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_slot  (w_wr_slot),
        .i_wr_entry (w_wr_entry),
        .i_rd_en    (w_rd_en),
        .i_rd_slot  (w_rd_slot),
        .o_rd_entry (w_rd_entry)
    );

    bel_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_desc     (w_desc),
        .i_rd_entry (w_rd_entry),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );

    // checks
    `BEL_ASSERT_RST(a_out_idle_after_rst, !i_rst_n |=> !o_out.valid, "result valid after reset")
    `BEL_ASSERT(a_clear_gives_result, (i_in.valid && i_in.ready && i_in.command == CMD_CLEAR) |=> w_desc.valid, "clear without result")
    `BEL_ASSERT(a_cursor_tracks_fill, w_flags.cursor_valid == !w_flags.empty, "cursor validity disagrees with fill")
    `BEL_ASSERT(a_out_from_desc, $rose(o_out.valid) |-> $past(w_desc.valid), "result without descriptor")
endmodule
